>>> src/m3uf_pkg.sv
// ----------------------------------------------------------------------------
// m3uf_pkg
// shared types and codes for the mod-3 relation union-find block
// ----------------------------------------------------------------------------
package m3uf_pkg;

    localparam int COUNT_W = 16;
    localparam int ELEM_W  = 9;
    localparam int EXCL_W  = 10;

    typedef enum logic [2:0] {
        STATUS_IGNORED    = 3'd0,
        STATUS_CONSISTENT = 3'd1,
        STATUS_LINKED     = 3'd2,
        STATUS_CONFLICT   = 3'd3,
        STATUS_CLEARED    = 3'd4
    } status_t;

    typedef enum logic {
        MODE_CLEAR  = 1'b0,
        MODE_RELATE = 1'b1
    } mode_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK,
        S_COMP,
        S_DECIDE,
        S_LINK,
        S_CLR,
        S_FIN
    } fsm_t;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear;
    } tbl_ctrl_t;

endpackage

>>> src/mod3_relation_union_find.sv
// relate: walk and compress the parent chain of each element in turn, then decide and link
// ignored item goes straight to the result, clear item sweeps the memory one entry per cycle
// throughput: one transaction at a time, set by the serial parent/offset memory walk
// reset: asynchronous active low, then a clearing pass over all NODES entries before the first item
// a finished result waits in the output register while the next item is accepted
// ----------------------------------------------------------------------------
// mod3_relation_union_find
// union-find table with mod-3 offsets, path compression and conflict counting
// ----------------------------------------------------------------------------
module mod3_relation_union_find #(
    parameter int NODES = 512
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [9:0]  cfg_wdata,      // excluded_element
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,        // mode, first_element, second_element, relation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata         // status, conflict_count
);
    import m3uf_pkg::*;

    localparam int IW = $clog2(NODES);
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    fsm_t               state_reg, state_next;
    tbl_ctrl_t          ctrl;
    logic [IW-1:0]      rd_addr, wr_addr;
    logic [IW+1:0]      wr_data, rd_data;
    logic               tbl_busy;
    logic [IW-1:0]      rd_par;
    logic [1:0]         rd_off;

    logic [EXCL_W-1:0]  excl_reg;
    logic [IW-1:0]      v_reg, v_next;
    logic [1:0]         c_reg, c_next;
    logic [IW-1:0]      x_reg, x_next, r_reg, r_next;
    logic [IW-1:0]      root_u_reg, root_u_next, root_v_reg, root_v_next;
    logic [1:0]         sum_reg, sum_next, su_reg, su_next, sv_reg, sv_next;
    logic [1:0]         diff_reg, diff_next;
    logic               which_reg, which_next;
    status_t            status_reg, status_next;
    logic [COUNT_W-1:0] cnt_reg, cnt_next;
    logic               m_valid_reg, m_valid_next;
    status_t            m_status_reg, m_status_next;
    logic [COUNT_W-1:0] m_count_reg, m_count_next;

    logic               in_mode;
    logic [ELEM_W-1:0]  in_first, in_second;
    logic [1:0]         in_rel;
    logic               accept, ignore_item;
    logic [1:0]         alu_a, alu_b, alu_y;
    logic [IW-1:0]      cur_root;

    function automatic logic [1:0] mod3_add(input logic [1:0] a, input logic [1:0] b);
        logic [2:0] s;
        s = {1'b0, a} + {1'b0, b};
        return (s >= 3'd3) ? 2'(s - 3'd3) : s[1:0];
    endfunction

    function automatic logic [1:0] mod3_neg(input logic [1:0] a);
        return (a == 2'd0) ? 2'd0 : 2'(2'd3 - a);
    endfunction

    m3uf_table #(
        .NODES(NODES)
    ) u_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctrl    (ctrl),
        .rd_addr (rd_addr),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_data (rd_data),
        .busy    (tbl_busy)
    );

    assign rd_par = rd_data[IW+1:2];
    assign rd_off = rd_data[1:0];

    assign in_mode   = s_tdata[0];
    assign in_first  = s_tdata[9:1];
    assign in_second = s_tdata[18:10];
    assign in_rel    = s_tdata[20:19];

    assign s_tready = (state_reg == S_IDLE) && !tbl_busy;
    assign accept   = s_tvalid && s_tready;

    assign ignore_item = (int'(in_first) >= NODES) || (int'(in_second) >= NODES) ||
                         ({1'b0, in_first} == excl_reg) || ({1'b0, in_second} == excl_reg);

    assign cur_root = which_reg ? root_v_reg : root_u_reg;
    assign alu_y    = mod3_add(alu_a, alu_b);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (mode_t'(in_mode) == MODE_CLEAR)
                    begin
                        state_next = S_CLR;
                    end
                    else if (ignore_item)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_WALK;
                    end
                end
            end
            S_WALK:
            begin
                if (rd_par == r_reg)
                begin
                    state_next = S_COMP;
                end
            end
            S_COMP:
            begin
                if (r_reg == cur_root)
                begin
                    state_next = which_reg ? S_DECIDE : S_WALK;
                end
            end
            S_DECIDE:
            begin
                state_next = (root_u_reg == root_v_reg) ? S_FIN : S_LINK;
            end
            S_LINK:
            begin
                state_next = S_FIN;
            end
            S_CLR:
            begin
                if (!tbl_busy)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // datapath and memory requests
    always_comb
    begin
        ctrl          = '0;
        rd_addr       = '0;
        wr_addr       = '0;
        wr_data       = '0;
        alu_a         = '0;
        alu_b         = '0;
        v_next        = v_reg;
        c_next        = c_reg;
        x_next        = x_reg;
        r_next        = r_reg;
        root_u_next   = root_u_reg;
        root_v_next   = root_v_reg;
        sum_next      = sum_reg;
        su_next       = su_reg;
        sv_next       = sv_reg;
        diff_next     = diff_reg;
        which_next    = which_reg;
        status_next   = status_reg;
        cnt_next      = cnt_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_status_next = m_status_reg;
        m_count_next  = m_count_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    v_next = IW'(in_second);
                    c_next = (in_rel == 2'd3) ? 2'd0 : in_rel;
                    if (mode_t'(in_mode) == MODE_CLEAR)
                    begin
                        ctrl.clear = 1'b1;
                        cnt_next   = '0;
                    end
                    else if (ignore_item)
                    begin
                        status_next = STATUS_IGNORED;
                    end
                    else
                    begin
                        ctrl.rd_en = 1'b1;
                        rd_addr    = IW'(in_first);
                        x_next     = IW'(in_first);
                        r_next     = IW'(in_first);
                        sum_next   = '0;
                        which_next = 1'b0;
                    end
                end
            end
            S_WALK:
            begin
                if (rd_par == r_reg)
                begin
                    if (which_reg)
                    begin
                        root_v_next = r_reg;
                        sv_next     = sum_reg;
                    end
                    else
                    begin
                        root_u_next = r_reg;
                        su_next     = sum_reg;
                    end
                    r_next     = x_reg;
                    ctrl.rd_en = 1'b1;
                    rd_addr    = x_reg;
                end
                else
                begin
                    alu_a      = sum_reg;
                    alu_b      = rd_off;
                    sum_next   = alu_y;
                    r_next     = rd_par;
                    ctrl.rd_en = 1'b1;
                    rd_addr    = rd_par;
                end
            end
            S_COMP:
            begin
                if (r_reg == cur_root)
                begin
                    if (!which_reg)
                    begin
                        which_next = 1'b1;
                        x_next     = v_reg;
                        r_next     = v_reg;
                        sum_next   = '0;
                        ctrl.rd_en = 1'b1;
                        rd_addr    = v_reg;
                    end
                end
                else
                begin
                    ctrl.wr_en = 1'b1;
                    wr_addr    = r_reg;
                    wr_data    = {cur_root, sum_reg};
                    alu_a      = sum_reg;
                    alu_b      = mod3_neg(rd_off);
                    sum_next   = alu_y;
                    r_next     = rd_par;
                    ctrl.rd_en = 1'b1;
                    rd_addr    = rd_par;
                end
            end
            S_DECIDE:
            begin
                alu_a = su_reg;
                alu_b = mod3_neg(sv_reg);
                if (root_u_reg == root_v_reg)
                begin
                    if (alu_y == c_reg)
                    begin
                        status_next = STATUS_CONSISTENT;
                    end
                    else
                    begin
                        status_next = STATUS_CONFLICT;
                        if (cnt_reg != COUNT_MAX)
                        begin
                            cnt_next = cnt_reg + 1'b1;
                        end
                    end
                end
                else
                begin
                    diff_next = alu_y;
                end
            end
            S_LINK:
            begin
                alu_a       = c_reg;
                alu_b       = mod3_neg(diff_reg);
                ctrl.wr_en  = 1'b1;
                wr_addr     = root_u_reg;
                wr_data     = {root_v_reg, alu_y};
                status_next = STATUS_LINKED;
            end
            S_CLR:
            begin
                status_next = STATUS_CLEARED;
            end
            S_FIN:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    m_count_next  = cnt_reg;
                end
            end
            default:
            begin
                status_next = status_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            excl_reg    <= EXCL_W'(512);
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
            which_reg   <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
            which_reg   <= which_next;
            if (cfg_we)
            begin
                excl_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg        <= v_next;
        c_reg        <= c_next;
        x_reg        <= x_next;
        r_reg        <= r_next;
        root_u_reg   <= root_u_next;
        root_v_reg   <= root_v_next;
        sum_reg      <= sum_next;
        su_reg       <= su_next;
        sv_reg       <= sv_next;
        diff_reg     <= diff_next;
        status_reg   <= status_next;
        m_status_reg <= m_status_next;
        m_count_reg  <= m_count_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {5'd0, m_count_reg, m_status_reg};

    // no table access from the sequencer while the sweep owns the memory
    a_no_access_during_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.wr_en || ctrl.rd_en) |-> !tbl_busy)
        else $error("table access during clearing sweep");

    a_link_distinct_roots: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_LINK) |-> (root_u_reg != root_v_reg))
        else $error("link of a root to itself");

    a_conflict_counted: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && (m_status_reg == STATUS_CONFLICT)) |-> (m_count_reg != '0))
        else $error("conflict reported with zero count");

    a_cleared_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_valid_reg && (m_status_reg == STATUS_CLEARED)) |-> (m_count_reg == '0))
        else $error("clear reported with nonzero count");

    a_clear_starts_sweep: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.clear |=> tbl_busy)
        else $error("clear did not start sweep");

endmodule

>>> src/m3uf_table.sv
// ----------------------------------------------------------------------------
// m3uf_table
// parent/offset memory with one read and one write port and a clearing sweep
// ----------------------------------------------------------------------------
module m3uf_table #(
    parameter int NODES = 512
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  m3uf_pkg::tbl_ctrl_t          ctrl,
    input  logic [$clog2(NODES)-1:0]     rd_addr,
    input  logic [$clog2(NODES)-1:0]     wr_addr,
    input  logic [$clog2(NODES)+1:0]     wr_data,
    output logic [$clog2(NODES)+1:0]     rd_data,
    output logic                         busy
);
    import m3uf_pkg::*;

    localparam int IW = $clog2(NODES);
    localparam logic [IW-1:0] LAST = IW'(NODES - 1);

    logic [IW+1:0] mem [NODES];
    logic [IW+1:0] rd_data_reg;
    logic          busy_reg, busy_next;
    logic [IW-1:0] sweep_reg, sweep_next;
    logic          mem_we;
    logic [IW-1:0] mem_waddr;
    logic [IW+1:0] mem_wdata;

    always_comb
    begin
        busy_next  = busy_reg;
        sweep_next = sweep_reg;
        if (ctrl.clear)
        begin
            busy_next  = 1'b1;
            sweep_next = '0;
        end
        else if (busy_reg)
        begin
            if (sweep_reg == LAST)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                sweep_next = sweep_reg + 1'b1;
            end
        end
    end

    always_comb
    begin
        if (busy_reg)
        begin
            mem_we    = 1'b1;
            mem_waddr = sweep_reg;
            mem_wdata = {sweep_reg, 2'b00};
        end
        else
        begin
            mem_we    = ctrl.wr_en;
            mem_waddr = wr_addr;
            mem_wdata = wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b1;
            sweep_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            sweep_reg <= sweep_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (ctrl.rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = busy_reg;

endmodule
